// ----- hdl/assert_macros.svh -----
// Shared assertion macros: every property is sampled on the rising clock edge
// and is ignored while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hdl/lrupr_pkg.sv -----
`default_nettype none
package lrupr_pkg;

   localparam int SLOT_W_MAX  = 6;   // slot index width at the largest frame count
   localparam int CNT_W_MAX   = 7;   // valid count width at the largest frame count
   localparam int CFG_W       = 5;
   localparam int PAGE_IN_W   = 16;
   localparam int SLOT_OUT_W  = 4;
   localparam int FAULT_W     = 16;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 24;
   localparam int CSR_DATA_W  = 8;
   localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_TOUCH,
      ST_FINISH
   } lrupr_state_type;

   // Outcome of one scan over the frames.
   typedef struct packed {
      logic                  found;
      logic                  has_empty;
      logic [SLOT_W_MAX-1:0] slot;
      logic [SLOT_W_MAX-1:0] rank;
      logic [CNT_W_MAX-1:0]  vcount;
   } lrupr_scan_type;

   // Write strobes into the frame store.
   typedef struct packed {
      logic page_we;
      logic rank_we;
      logic valid_set;
      logic clear_all;
   } lrupr_wr_type;

endpackage
`default_nettype wire

// ----- hdl/lru_page_replacement.sv -----
// An accepted request is scanned over the frames (ST_SCAN) and resolved (ST_DECIDE);
// a hit or a replacement then walks the frames again (ST_TOUCH), a fill of an empty
// frame goes straight on; rsp_tvalid rises from ST_FINISH. One transaction is in work
// at a time, the next accepted in ST_IDLE; a result held by rsp_tready stalls the finish.
// Reset (synchronous, active high) empties all frames, clears the fault count and sets
// frames_in_use to 16; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"
module lru_page_replacement
   import lrupr_pkg::*;
#(
   parameter int FRAME_SLOTS = 16,
   parameter int PAGE_BITS   = 16
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [REQ_DATA_W-1:0] req_tdata,   // [15:0] page_number
   input  wire logic                  req_tlast,   // last_reference
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic      [RSP_DATA_W-1:0] rsp_tdata,   // [3:0] frame_slot, [19:4] fault_count
   output logic                       rsp_tuser,   // hit
   output logic                       rsp_tlast,   // end_of_sequence
   input  wire logic                  csr_tvalid,
   output logic                       csr_tready,
   input  wire logic [CSR_DATA_W-1:0] csr_tdata    // [4:0] frames_in_use
);

   localparam int SW = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
   localparam int CW = $clog2(FRAME_SLOTS + 1);
   localparam int AW = (SW + 1 > CFG_W) ? SW + 1 : CFG_W;
   localparam logic [CW-1:0] LAST_CTR = CW'(FRAME_SLOTS);

   lrupr_state_type state_ff, state_in;

   logic [CW-1:0]         ctr_ff, ctr_in;
   logic                  rd_pend_ff;
   logic [SW-1:0]         rd_idx_ff;
   logic [PAGE_BITS-1:0]  tag_ff, tag_in;
   logic                  last_ff, last_in;
   logic [SW-1:0]         slot_ff, slot_in;
   logic [SW-1:0]         trank_ff, trank_in;
   logic [SW-1:0]         nrank_ff, nrank_in;
   logic                  hit_ff, hit_in;
   logic [FAULT_W-1:0]    fault_ff, fault_in;
   logic [CFG_W-1:0]      frames_ff, frames_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_hit_ff, rsp_hit_in;
   logic [SLOT_OUT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [FAULT_W-1:0]    rsp_fault_ff, rsp_fault_in;
   logic                  rsp_last_ff, rsp_last_in;

   logic                  req_accept;
   logic                  issue;
   logic                  finish_go;
   logic                  scan_clear;
   logic                  scan_step;
   lrupr_wr_type          wr;
   logic [SW-1:0]         waddr;
   logic [SW-1:0]         rank_wdata;
   logic [PAGE_BITS-1:0]  rd_page;
   logic [SW-1:0]         rd_rank;
   logic                  rd_valid;
   logic [CFG_W-1:0]      frames_eff;
   logic                  slot_active;
   lrupr_scan_type        scan_res;
   logic [CW-1:0]         res_vcount;
   logic                  self_slot;

   assign req_accept = req_tvalid && req_tready;
   assign csr_tready = 1'b1;

   // zero frames behaves as one; a count above the store size never matters since
   // the scan index stays below it
   assign frames_eff  = (frames_ff == '0) ? CFG_W'(1) : frames_ff;
   assign slot_active = (AW'(rd_idx_ff) < AW'(frames_eff));
   assign res_vcount  = CW'(scan_res.vcount);
   assign self_slot   = (rd_idx_ff == slot_ff);

   lrupr_store #(
      .FRAME_SLOTS (FRAME_SLOTS),
      .PAGE_BITS   (PAGE_BITS)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .wr         (wr),
      .waddr      (waddr),
      .page_wdata (tag_ff),
      .rank_wdata (rank_wdata),
      .rd_addr    (ctr_ff[SW-1:0]),
      .rd_page    (rd_page),
      .rd_rank    (rd_rank),
      .rd_valid   (rd_valid)
   );

   lrupr_scan #(
      .FRAME_SLOTS (FRAME_SLOTS),
      .PAGE_BITS   (PAGE_BITS)
   ) u_scan (
      .clock       (clock),
      .reset       (reset),
      .clear       (scan_clear),
      .step        (scan_step),
      .slot_idx    (rd_idx_ff),
      .slot_active (slot_active),
      .slot_valid  (rd_valid),
      .slot_page   (rd_page),
      .slot_rank   (rd_rank),
      .tag         (tag_ff),
      .result      (scan_res)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (ctr_ff == LAST_CTR) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (scan_res.found || !scan_res.has_empty) begin
               state_in = ST_TOUCH;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_TOUCH: begin
            if (ctr_ff == LAST_CTR) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (finish_go) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control outputs
   always_comb begin
      req_tready    = 1'b0;
      issue         = 1'b0;
      finish_go     = 1'b0;
      scan_clear    = 1'b0;
      scan_step     = 1'b0;
      wr            = '0;
      waddr         = rd_idx_ff;
      rank_wdata    = rd_rank - SW'(1);
      unique case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            scan_clear = 1'b1;
         end
         ST_SCAN: begin
            issue     = (ctr_ff != LAST_CTR);
            scan_step = rd_pend_ff;
         end
         ST_DECIDE: begin
            waddr         = SW'(scan_res.slot);
            rank_wdata    = SW'(res_vcount);
            wr.page_we    = !scan_res.found;
            wr.rank_we    = !scan_res.found && scan_res.has_empty;
            wr.valid_set  = !scan_res.found && scan_res.has_empty;
         end
         ST_TOUCH: begin
            issue = (ctr_ff != LAST_CTR);
            // move the target to the top and drop every valid rank above its old one
            wr.rank_we = rd_pend_ff && (self_slot || (rd_valid && (rd_rank > trank_ff)));
            if (self_slot) begin
               rank_wdata = nrank_ff;
            end
         end
         ST_FINISH: begin
            finish_go    = !rsp_valid_ff || rsp_tready;
            wr.clear_all = finish_go && last_ff;
         end
         default: begin
         end
      endcase
   end

   // datapath
   always_comb begin
      ctr_in       = ctr_ff;
      tag_in       = tag_ff;
      last_in      = last_ff;
      slot_in      = slot_ff;
      trank_in     = trank_ff;
      nrank_in     = nrank_ff;
      hit_in       = hit_ff;
      fault_in     = fault_ff;
      frames_in    = frames_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_hit_in   = rsp_hit_ff;
      rsp_slot_in  = rsp_slot_ff;
      rsp_fault_in = rsp_fault_ff;
      rsp_last_in  = rsp_last_ff;

      if (csr_tvalid && csr_tready) begin
         frames_in = csr_tdata[CFG_W-1:0];
      end
      if (issue) begin
         ctr_in = ctr_ff + CW'(1);
      end
      if (req_accept) begin
         ctr_in  = '0;
         tag_in  = PAGE_BITS'(req_tdata[PAGE_IN_W-1:0]);
         last_in = req_tlast;
      end
      if (state_ff == ST_DECIDE) begin
         ctr_in   = '0;
         slot_in  = SW'(scan_res.slot);
         trank_in = SW'(scan_res.rank);
         nrank_in = SW'(res_vcount - CW'(1));
         hit_in   = scan_res.found;
         if (!scan_res.found && (fault_ff != '1)) begin
            fault_in = fault_ff + FAULT_W'(1);
         end
      end
      if (finish_go) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit_ff;
         rsp_slot_in  = SLOT_OUT_W'(slot_ff);
         rsp_fault_in = fault_ff;
         rsp_last_in  = last_ff;
         if (last_ff) begin
            fault_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ctr_ff       <= '0;
         rd_pend_ff   <= 1'b0;
         fault_ff     <= '0;
         frames_ff    <= CFG_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ctr_ff       <= ctr_in;
         rd_pend_ff   <= issue;
         fault_ff     <= fault_in;
         frames_ff    <= frames_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff    <= ctr_ff[SW-1:0];
      tag_ff       <= tag_in;
      last_ff      <= last_in;
      slot_ff      <= slot_in;
      trank_ff     <= trank_in;
      nrank_ff     <= nrank_in;
      hit_ff       <= hit_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_fault_ff <= rsp_fault_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = {{(RSP_DATA_W - SLOT_OUT_W - FAULT_W){1'b0}}, rsp_fault_ff, rsp_slot_ff};

   `ASSERT_NEXT(a_accept_starts_scan, req_accept, (state_ff == ST_SCAN) && (ctr_ff == '0),
      "accepted transaction did not start a scan at frame zero")
   `ASSERT_IMPL(a_rsp_from_finish, $rose(rsp_tvalid), $past(state_ff == ST_FINISH),
      "result raised outside the finish step")
   `ASSERT_NEXT(a_fault_monotonic, state_ff == ST_DECIDE, fault_ff >= $past(fault_ff),
      "fault count dropped while resolving a reference")
   `ASSERT_NEXT(a_last_clears_faults, finish_go && last_ff, fault_ff == '0,
      "fault count not cleared after the end of a sequence")

endmodule
`default_nettype wire

// ----- hdl/lrupr_store.sv -----
`default_nettype none
module lrupr_store
   import lrupr_pkg::*;
#(
   parameter int FRAME_SLOTS = 16,
   parameter int PAGE_BITS   = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire lrupr_wr_type         wr,
   input  wire logic [((FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1)-1:0] waddr,
   input  wire logic [PAGE_BITS-1:0] page_wdata,
   input  wire logic [((FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1)-1:0] rank_wdata,
   input  wire logic [((FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1)-1:0] rd_addr,
   output logic      [PAGE_BITS-1:0] rd_page,
   output logic      [((FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1)-1:0] rd_rank,
   output logic                      rd_valid
);

   localparam int SW = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;

   logic [PAGE_BITS-1:0]   page_mem [FRAME_SLOTS];
   logic [SW-1:0]          rank_mem [FRAME_SLOTS];
   logic [FRAME_SLOTS-1:0] valid_ff, valid_in;
   logic [PAGE_BITS-1:0]   rd_page_ff;
   logic [SW-1:0]          rd_rank_ff;
   logic                   rd_valid_ff;

   always_comb begin
      valid_in = valid_ff;
      if (wr.clear_all) begin
         valid_in = '0;
      end else if (wr.valid_set) begin
         valid_in[waddr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr.page_we) begin
         page_mem[waddr] <= page_wdata;
      end
      if (wr.rank_we) begin
         rank_mem[waddr] <= rank_wdata;
      end
      rd_page_ff  <= page_mem[rd_addr];
      rd_rank_ff  <= rank_mem[rd_addr];
      rd_valid_ff <= valid_ff[rd_addr];
   end

   assign rd_page  = rd_page_ff;
   assign rd_rank  = rd_rank_ff;
   assign rd_valid = rd_valid_ff;

endmodule
`default_nettype wire

// ----- hdl/lrupr_scan.sv -----
`default_nettype none
module lrupr_scan
   import lrupr_pkg::*;
#(
   parameter int FRAME_SLOTS = 16,
   parameter int PAGE_BITS   = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 clear,
   input  wire logic                 step,
   input  wire logic [((FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1)-1:0] slot_idx,
   input  wire logic                 slot_active,
   input  wire logic                 slot_valid,
   input  wire logic [PAGE_BITS-1:0] slot_page,
   input  wire logic [((FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1)-1:0] slot_rank,
   input  wire logic [PAGE_BITS-1:0] tag,
   output lrupr_scan_type            result
);

   localparam int SW = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
   localparam int CW = $clog2(FRAME_SLOTS + 1);

   logic          found_ff, found_in;
   logic          empty_ff, empty_in;
   logic [CW-1:0] vcnt_ff, vcnt_in;
   logic [SW-1:0] hit_slot_ff, hit_slot_in;
   logic [SW-1:0] hit_rank_ff, hit_rank_in;
   logic [SW-1:0] empty_slot_ff, empty_slot_in;
   logic [SW-1:0] lru_slot_ff, lru_slot_in;
   logic [SW-1:0] lru_rank_ff, lru_rank_in;
   logic          rank_lower;

   // the one rank comparator, walked over the frames one per cycle
   assign rank_lower = (slot_rank < lru_rank_ff);

   always_comb begin
      found_in      = found_ff;
      empty_in      = empty_ff;
      vcnt_in       = vcnt_ff;
      hit_slot_in   = hit_slot_ff;
      hit_rank_in   = hit_rank_ff;
      empty_slot_in = empty_slot_ff;
      lru_slot_in   = lru_slot_ff;
      lru_rank_in   = lru_rank_ff;
      if (clear) begin
         found_in = 1'b0;
         empty_in = 1'b0;
         vcnt_in  = '0;
      end else if (step) begin
         vcnt_in = vcnt_ff + CW'(slot_valid);
         if (slot_active && slot_valid && !found_ff && (slot_page == tag)) begin
            found_in    = 1'b1;
            hit_slot_in = slot_idx;
            hit_rank_in = slot_rank;
         end
         if (slot_active && !slot_valid && !empty_ff) begin
            empty_in      = 1'b1;
            empty_slot_in = slot_idx;
         end
         // strict compare keeps the lowest-numbered frame on a tie
         if (slot_active && ((slot_idx == '0) || rank_lower)) begin
            lru_slot_in = slot_idx;
            lru_rank_in = slot_rank;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
         empty_ff <= 1'b0;
         vcnt_ff  <= '0;
      end else begin
         found_ff <= found_in;
         empty_ff <= empty_in;
         vcnt_ff  <= vcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      hit_slot_ff   <= hit_slot_in;
      hit_rank_ff   <= hit_rank_in;
      empty_slot_ff <= empty_slot_in;
      lru_slot_ff   <= lru_slot_in;
      lru_rank_ff   <= lru_rank_in;
   end

   always_comb begin
      result.found     = found_ff;
      result.has_empty = empty_ff;
      result.vcount    = CNT_W_MAX'(vcnt_ff);
      result.rank      = SLOT_W_MAX'(found_ff ? hit_rank_ff : lru_rank_ff);
      if (found_ff) begin
         result.slot = SLOT_W_MAX'(hit_slot_ff);
      end else if (empty_ff) begin
         result.slot = SLOT_W_MAX'(empty_slot_ff);
      end else begin
         result.slot = SLOT_W_MAX'(lru_slot_ff);
      end
   end

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
module tb
   import lrupr_pkg::*;
();

   localparam int SLOTS = 16;
   localparam int POOL_SIZE = 24;
   localparam int RANDOM_ITEMS = 1700;
   localparam int DRAIN_CYCLES = 40;
   localparam longint CYCLE_LIMIT = 1_000_000;
   localparam logic [FAULT_W-1:0] FAULT_CEILING = '1;

   typedef struct packed {
      logic                  hit;
      logic [SLOT_OUT_W-1:0] slot;
      logic [FAULT_W-1:0]    faults;
      logic                  eos;
   } page_outcome_type;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // [15:0] page_number
   logic                  req_tlast;   // last_reference
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // [3:0] frame_slot, [19:4] fault_count
   logic                  rsp_tuser;   // hit
   logic                  rsp_tlast;   // end_of_sequence
   logic                  csr_tvalid;
   logic                  csr_tready;
   logic [CSR_DATA_W-1:0] csr_tdata;   // [4:0] frames_in_use

   lru_page_replacement dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_tvalid (csr_tvalid),
      .csr_tready (csr_tready),
      .csr_tdata  (csr_tdata)
   );

   // Predicted frame table
   logic [CFG_W-1:0]     frames_cfg;
   logic [PAGE_IN_W-1:0] frame_tag [SLOTS];
   bit                   frame_live [SLOTS];
   logic [3:0]           frame_age [SLOTS];
   logic [FAULT_W-1:0]   fault_tally;

   page_outcome_type outcome_q[$];
   page_outcome_type want;
   int               mismatches;
   bit               quiet;
   longint           cycles;

   always #5 clock = ~clock;

   function automatic void clear_frames();
      for (int i = 0; i < SLOTS; i++) begin
         frame_tag[i] = '0;
         frame_live[i] = 1'b0;
         frame_age[i] = '0;
      end
      fault_tally = '0;
   endfunction

   function automatic logic [4:0] live_count();
      logic [4:0] n;
      n = '0;
      for (int i = 0; i < SLOTS; i++)
         if (frame_live[i])
            n++;
      return n;
   endfunction

   // Make frame f the most recent; ranks above it slide down.
   function automatic void promote(int f);
      logic [3:0] r;
      logic [4:0] v;
      r = frame_age[f];
      v = live_count();
      for (int i = 0; i < SLOTS; i++)
         if (frame_live[i] && frame_age[i] > r)
            frame_age[i]--;
      frame_age[f] = 4'(v - 5'd1);
   endfunction

   function automatic page_outcome_type lookup_page(logic [PAGE_IN_W-1:0] page, logic last);
      int               active;
      int               slot;
      bit               found;
      bit               empty;
      logic [3:0]       oldest;
      page_outcome_type o;
      active = int'(frames_cfg);
      if (active == 0)
         active = 1;
      if (active > SLOTS)
         active = SLOTS;
      found = 1'b0;
      slot = 0;
      for (int i = 0; i < active && !found; i++)
         if (frame_live[i] && frame_tag[i] == page) begin
            slot = i;
            found = 1'b1;
         end
      if (found) begin
         promote(slot);
      end else begin
         empty = 1'b0;
         for (int i = 0; i < active && !empty; i++)
            if (!frame_live[i]) begin
               slot = i;
               empty = 1'b1;
            end
         if (empty) begin
            frame_age[slot] = 4'(live_count());
            frame_live[slot] = 1'b1;
         end else begin
            // strict compare keeps the lowest frame on a tie
            slot = 0;
            oldest = frame_age[0];
            for (int i = 1; i < active; i++)
               if (frame_age[i] < oldest) begin
                  oldest = frame_age[i];
                  slot = i;
               end
            promote(slot);
         end
         frame_tag[slot] = page;
         if (fault_tally != FAULT_CEILING)
            fault_tally++;
      end
      o.hit = found;
      o.slot = SLOT_OUT_W'(slot);
      o.faults = fault_tally;
      o.eos = last;
      if (last)
         clear_frames();
      return o;
   endfunction

   function automatic logic [CFG_W-1:0] pick_frames();
      unique case ($urandom_range(0, 7))
         0: return 5'd0;
         1: return 5'd1;
         2: return 5'd16;
         3: return 5'd31;
         4: return CFG_W'($urandom_range(17, 30));
         default: return CFG_W'($urandom_range(1, 16));
      endcase
   endfunction

   task automatic send_page(logic [PAGE_IN_W-1:0] page, logic last);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 19);
      if (gap > 0) begin
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata <= page;
      req_tlast <= last;
      do @(posedge clock); while (!req_tready);
      outcome_q.push_back(lookup_page(page, last));
   endtask

   // Hold the request side until every outstanding transaction has returned.
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Call only after drain().
   task automatic write_frames(logic [CFG_W-1:0] n);
      @(negedge clock);
      csr_tvalid <= 1'b1;
      csr_tdata <= CSR_DATA_W'(n);
      do @(posedge clock); while (!csr_tready);
      frames_cfg = n;
      @(negedge clock);
      csr_tvalid <= 1'b0;
   endtask

   task automatic test_defaults();
      send_page(16'h0000, 1'b0);
      send_page(16'hFFFF, 1'b0);
      send_page(16'h0000, 1'b0);
      send_page(16'h5555, 1'b1);
   endtask

   task automatic test_single_frame();
      drain();
      write_frames(5'd0);
      send_page(16'h1234, 1'b0);
      send_page(16'h1234, 1'b0);
      send_page(16'h4321, 1'b0);
      send_page(16'hAAAA, 1'b1);
   endtask

   // Shrink with frames still valid above the limit, then grow back over them.
   task automatic test_shrink_keeps_frames();
      drain();
      write_frames(5'd4);
      send_page(16'h0A01, 1'b0);
      send_page(16'h0A02, 1'b0);
      send_page(16'h0A03, 1'b0);
      send_page(16'h0A04, 1'b0);
      drain();
      write_frames(5'd2);
      send_page(16'h0A05, 1'b0);
      send_page(16'h0A03, 1'b0);
      drain();
      write_frames(5'd4);
      send_page(16'h0A03, 1'b0);
      send_page(16'h0A04, 1'b1);
   endtask

   task automatic test_random_sequences();
      int                   sent;
      int                   seq_len;
      int                   ws;
      logic [PAGE_IN_W-1:0] pool [POOL_SIZE];
      logic [PAGE_IN_W-1:0] page;
      bit                   last;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         quiet = ($urandom_range(0, 4) == 0);
         if ($urandom_range(0, 1) == 0) begin
            drain();
            write_frames(pick_frames());
         end
         seq_len = $urandom_range(1, 60);
         ws = $urandom_range(1, POOL_SIZE);
         for (int i = 0; i < POOL_SIZE; i++)
            pool[i] = PAGE_IN_W'($urandom);
         for (int k = 0; k < seq_len; k++) begin
            if ($urandom_range(0, 39) == 0) begin
               drain();
               if ($urandom_range(0, 1) == 0)
                  write_frames(pick_frames());
            end
            if ($urandom_range(0, 9) < 7)
               page = pool[$urandom_range(0, ws - 1)];
            else
               page = PAGE_IN_W'($urandom);
            // mostly end on the final reference; sometimes run on or cut early
            if (k == seq_len - 1)
               last = ($urandom_range(0, 7) != 0);
            else
               last = ($urandom_range(0, 49) == 0);
            send_page(page, last);
            sent++;
         end
      end
      quiet = 1'b0;
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tlast = 1'b0;
      csr_tvalid = 1'b0;
      csr_tdata = '0;
      quiet = 1'b0;
      mismatches = 0;
      cycles = 0;
      frames_cfg = CFG_RESET;
      clear_frames();
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_defaults();
      test_single_frame();
      test_shrink_keeps_frames();
      test_random_sequences();
      drain();
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

   initial begin : rsp_side
      int stall;
      rsp_tready = 1'b0;
      wait (reset === 1'b0);
      forever begin
         stall = quiet ? 0 : $urandom_range(0, 19);
         if (stall > 0) begin
            @(negedge clock);
            rsp_tready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_tready <= 1'b1;
         do @(posedge clock); while (reset || rsp_tvalid !== 1'b1);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (outcome_q.size() == 0) begin
            $error("unexpected transaction: frame_slot %0d fault_count %0d",
                   rsp_tdata[3:0], rsp_tdata[19:4]);
            mismatches++;
         end else begin
            want = outcome_q.pop_front();
            if (rsp_tuser !== want.hit) begin
               $error("hit: expected %0d, got %0d", want.hit, rsp_tuser);
               mismatches++;
            end
            if (rsp_tdata[3:0] !== want.slot) begin
               $error("frame_slot: expected %0d, got %0d", want.slot, rsp_tdata[3:0]);
               mismatches++;
            end
            if (rsp_tdata[19:4] !== want.faults) begin
               $error("fault_count: expected %0d, got %0d", want.faults, rsp_tdata[19:4]);
               mismatches++;
            end
            if (rsp_tlast !== want.eos) begin
               $error("end_of_sequence: expected %0d, got %0d", want.eos, rsp_tlast);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

endmodule
